// File: rtl/core/priority_lock_manager_assert.svh
// ----------------------------------------------------------------------------
// priority_lock_manager_assert
// assertion macros shared by the lock manager rtl
// ----------------------------------------------------------------------------
`ifndef PRIORITY_LOCK_MANAGER_ASSERT_SVH
`define PRIORITY_LOCK_MANAGER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PLM_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("lock manager check failed");

// next-cycle implication, checked out of reset
`define PLM_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("lock manager check failed");

`endif

// File: rtl/core/plm_pkg.sv
// ----------------------------------------------------------------------------
// plm_pkg
// types, codes and sizes shared by the priority lock manager
// ----------------------------------------------------------------------------
`default_nettype none

package plm_pkg;

    localparam int PLM_MAX_REQUESTERS = 64;
    localparam int PLM_ID_W           = 6;
    localparam int PLM_PRIO_W         = 8;
    localparam int PLM_EVENT_W        = 3;
    localparam int PLM_COUNT_W        = 7;
    localparam int PLM_NUM_IDS        = 2 ** PLM_ID_W;

    // request actions
    localparam logic ACT_ACQUIRE = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    // result events
    localparam logic [PLM_EVENT_W-1:0] EV_GRANTED = 3'd0;
    localparam logic [PLM_EVENT_W-1:0] EV_QUEUED  = 3'd1;
    localparam logic [PLM_EVENT_W-1:0] EV_HANDED  = 3'd2;
    localparam logic [PLM_EVENT_W-1:0] EV_FREED   = 3'd3;
    localparam logic [PLM_EVENT_W-1:0] EV_IGNORED = 3'd4;

    typedef struct packed {
        logic                  action;
        logic [PLM_ID_W-1:0]   requester_id;
        logic [PLM_PRIO_W-1:0] priority_req;
    } plm_req_t;

    typedef struct packed {
        logic [PLM_EVENT_W-1:0] event_res;
        logic [PLM_ID_W-1:0]    owner_id;
        logic                   lock_held;
        logic [PLM_COUNT_W-1:0] waiter_count;
    } plm_rsp_t;

    // one queued waiter
    typedef struct packed {
        logic [PLM_ID_W-1:0]   id;
        logic [PLM_PRIO_W-1:0] prio;
    } plm_waiter_t;

endpackage

`default_nettype wire

// File: rtl/core/plm_queue_ram.sv
// ----------------------------------------------------------------------------
// plm_queue_ram
// waiter queue storage: one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module plm_queue_ram #(
    parameter int DEPTH = plm_pkg::PLM_MAX_REQUESTERS
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire plm_pkg::plm_waiter_t       wr_data,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output plm_pkg::plm_waiter_t            rd_data
);
    import plm_pkg::*;

    plm_waiter_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/priority_lock_manager.sv
// ----------------------------------------------------------------------------
// priority_lock_manager
// lock with priority hand-off to a queue of waiters
// ----------------------------------------------------------------------------
//
//  channel  dir  payload    handshake
//  req      in   plm_req_t  req_valid / req_ready
//  rsp      out  plm_rsp_t  rsp_valid / rsp_ready
//
//  acquire, and a release with no waiters: the done state, then the output register
//  release with waiters: one priority comparator scans the queue ram, then
//  one ram read and write a cycle compact it
//  one beat in work at a time; a finished result waits in the output register
//  while the next beat is taken
//  reset clears lock, owner, count and waiting marks; no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

`include "priority_lock_manager_assert.svh"

module priority_lock_manager #(
    parameter int MAX_REQUESTERS = plm_pkg::PLM_MAX_REQUESTERS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire plm_pkg::plm_req_t  req,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output plm_pkg::plm_rsp_t       rsp
);
    import plm_pkg::*;

    localparam int IDX_W = $clog2(MAX_REQUESTERS);
    localparam int CNT_W = $clog2(MAX_REQUESTERS + 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN     = 3'd1;
    localparam logic [2:0] ST_SCAN_END = 3'd2;
    localparam logic [2:0] ST_PREP     = 3'd3;
    localparam logic [2:0] ST_SHIFT    = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;

    // control state
    logic [2:0]             state_reg, state_next;
    logic                   held_reg, held_next;
    logic [PLM_ID_W-1:0]    owner_reg, owner_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [PLM_NUM_IDS-1:0] marks_reg, marks_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic                   wvld_reg, wvld_next;
    logic                   rsp_valid_reg, rsp_valid_next;

    // datapath state
    logic [PLM_EVENT_W-1:0] ev_reg, ev_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]       widx_reg, widx_next;
    logic                   first_reg, first_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [PLM_PRIO_W-1:0]  best_prio_reg, best_prio_next;
    logic [PLM_ID_W-1:0]    best_id_reg, best_id_next;
    plm_rsp_t               rsp_reg, rsp_next;

    // queue ram ports
    logic                   ram_wr_en;
    logic [IDX_W-1:0]       ram_wr_addr;
    plm_waiter_t            ram_wr_data;
    logic                   ram_rd_en;
    logic [IDX_W-1:0]       ram_rd_addr;
    plm_waiter_t            ram_rd_data;

    logic                   id_in_range;
    logic                   queue_full;
    logic                   better;

    plm_queue_ram #(
        .DEPTH (MAX_REQUESTERS)
    ) u_queue (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign id_in_range = (32'(req.requester_id) < MAX_REQUESTERS);
    assign queue_full  = (count_reg >= CNT_W'(MAX_REQUESTERS));

    // the shared comparator: strictly greater keeps the newer waiter on a tie,
    // since the scan runs newest to oldest
    assign better = first_reg || (ram_rd_data.prio > best_prio_reg);

    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        owner_next     = owner_reg;
        count_next     = count_reg;
        marks_next     = marks_reg;
        ev_next        = ev_reg;
        idx_next       = idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        widx_next      = widx_reg;
        first_next     = first_reg;
        best_idx_next  = best_idx_reg;
        best_prio_next = best_prio_reg;
        best_id_next   = best_id_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        cmp_vld_next   = 1'b0;
        wvld_next      = 1'b0;

        ram_rd_en   = 1'b0;
        ram_rd_addr = idx_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = widx_reg;
        ram_wr_data = ram_rd_data;

        // compare stage, working in the cycle after each scan read
        if (cmp_vld_reg)
        begin
            first_next = 1'b0;
            if (better)
            begin
                best_idx_next  = cmp_idx_reg;
                best_prio_next = ram_rd_data.prio;
                best_id_next   = ram_rd_data.id;
            end
        end

        // compaction write, in the cycle after its read
        if (wvld_reg)
        begin
            ram_wr_en = 1'b1;
        end

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DONE;
                    if (req.action == ACT_ACQUIRE)
                    begin
                        if (!id_in_range)
                        begin
                            ev_next = EV_IGNORED;
                        end
                        else if (!held_reg)
                        begin
                            held_next  = 1'b1;
                            owner_next = req.requester_id;
                            ev_next    = EV_GRANTED;
                        end
                        else if (marks_reg[req.requester_id] || queue_full)
                        begin
                            ev_next = EV_IGNORED;
                        end
                        else
                        begin
                            // append at the tail, newest last
                            ram_wr_en        = 1'b1;
                            ram_wr_addr      = IDX_W'(count_reg);
                            ram_wr_data.id   = req.requester_id;
                            ram_wr_data.prio = req.priority_req;
                            marks_next[req.requester_id] = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                            ev_next    = EV_QUEUED;
                        end
                    end
                    else
                    begin
                        if (!held_reg)
                        begin
                            ev_next = EV_IGNORED;
                        end
                        else if (count_reg == '0)
                        begin
                            held_next  = 1'b0;
                            owner_next = '0;
                            ev_next    = EV_FREED;
                        end
                        else
                        begin
                            idx_next   = IDX_W'(count_reg - CNT_W'(1));
                            first_next = 1'b1;
                            state_next = ST_SCAN;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                // newest to oldest, one entry a cycle
                ram_rd_en    = 1'b1;
                ram_rd_addr  = idx_reg;
                cmp_vld_next = 1'b1;
                cmp_idx_next = idx_reg;
                if (idx_reg == '0)
                begin
                    state_next = ST_SCAN_END;
                end
                else
                begin
                    idx_next = idx_reg - IDX_W'(1);
                end
            end

            ST_SCAN_END:
            begin
                // last compare retires this cycle
                state_next = ST_PREP;
            end

            ST_PREP:
            begin
                idx_next   = best_idx_reg;
                state_next = ST_SHIFT;
            end

            ST_SHIFT:
            begin
                // move each entry above the winner down by one
                if ((CNT_W'(idx_reg) + CNT_W'(1)) < count_reg)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = idx_reg + IDX_W'(1);
                    wvld_next   = 1'b1;
                    widx_next   = idx_reg;
                    idx_next    = idx_reg + IDX_W'(1);
                end
                else
                begin
                    count_next               = count_reg - CNT_W'(1);
                    marks_next[best_id_reg]  = 1'b0;
                    owner_next               = best_id_reg;
                    ev_next                  = EV_HANDED;
                    state_next               = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // hand the result to the output register once it is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.event_res    = ev_reg;
                    rsp_next.owner_id     = held_reg ? owner_reg : '0;
                    rsp_next.lock_held    = held_reg;
                    rsp_next.waiter_count = PLM_COUNT_W'(count_reg);
                    state_next            = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            held_reg      <= 1'b0;
            owner_reg     <= '0;
            count_reg     <= '0;
            marks_reg     <= '0;
            cmp_vld_reg   <= 1'b0;
            wvld_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            owner_reg     <= owner_next;
            count_reg     <= count_next;
            marks_reg     <= marks_next;
            cmp_vld_reg   <= cmp_vld_next;
            wvld_reg      <= wvld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_reg        <= ev_next;
        idx_reg       <= idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        widx_reg      <= widx_next;
        first_reg     <= first_next;
        best_idx_reg  <= best_idx_next;
        best_prio_reg <= best_prio_next;
        best_id_reg   <= best_id_next;
        rsp_reg       <= rsp_next;
    end

    // waiters only exist while someone owns the lock
    `PLM_ASSERT_IMPLIES(a_waiters_need_owner, clk, rst_n, count_reg != '0, held_reg)

    // one waiting mark per queued waiter
    `PLM_ASSERT_IMPLIES(a_marks_match_count, clk, rst_n, 1'b1,
        $countones(marks_reg) == 32'(count_reg))

    // a scan only runs over a non-empty queue of a held lock
    `PLM_ASSERT_IMPLIES(a_scan_has_work, clk, rst_n, state_reg == ST_SCAN,
        held_reg && (count_reg != '0))

    // a hand-off leaves the lock held
    `PLM_ASSERT_NEXT(a_handoff_keeps_lock, clk, rst_n,
        (state_reg == ST_SHIFT) && (state_next == ST_DONE), held_reg)

endmodule

`default_nettype wire

// File: test/priority_lock_checker.sv
// ----------------------------------------------------------------------------
// priority_lock_checker
// watches both channels of the lock manager, predicts each result beat from
// the request beats it has seen and compares them field by field
// ----------------------------------------------------------------------------
module priority_lock_checker import plm_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_ready,
    input  plm_req_t req,
    input  logic     rsp_valid,
    input  logic     rsp_ready,
    input  plm_rsp_t rsp,
    output int       mismatch_count,
    output int       outstanding,
    output int       results_checked,
    output int       handoff_count,
    output int       ignored_count,
    output int       peak_waiters
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QDEPTH = PLM_MAX_REQUESTERS;

    // lock state as the block should hold it
    logic                lock_taken = 1'b0;
    logic [PLM_ID_W-1:0] lock_owner = '0;
    int                  waiters    = 0;
    plm_waiter_t         waiter_q [QDEPTH];     // oldest at entry 0
    logic                is_waiting [PLM_NUM_IDS];

    plm_rsp_t            lock_results_due [$];
    int                  errs     = 0;
    int                  checked  = 0;
    int                  handoffs = 0;
    int                  ignores  = 0;
    int                  peak     = 0;

    // applies one request to the lock state and returns the result beat
    function automatic plm_rsp_t apply_lock_request(plm_req_t r);
        plm_rsp_t               res;
        int                     best;
        logic [PLM_EVENT_W-1:0] ev;
        if (r.action == ACT_ACQUIRE)
        begin
            if (int'(r.requester_id) >= QDEPTH)
            begin
                ev = EV_IGNORED;
            end
            else if (!lock_taken)
            begin
                lock_taken = 1'b1;
                lock_owner = r.requester_id;
                ev         = EV_GRANTED;
            end
            else if (is_waiting[r.requester_id] || waiters >= QDEPTH)
            begin
                ev = EV_IGNORED;
            end
            else
            begin
                waiter_q[waiters].id   = r.requester_id;
                waiter_q[waiters].prio = r.priority_req;
                is_waiting[r.requester_id] = 1'b1;
                waiters++;
                ev = EV_QUEUED;
            end
        end
        else if (!lock_taken)
        begin
            ev = EV_IGNORED;
        end
        else if (waiters == 0)
        begin
            lock_taken = 1'b0;
            lock_owner = '0;
            ev         = EV_FREED;
        end
        else
        begin
            // newest to oldest, strict compare keeps the newest of equals
            best = waiters - 1;
            for (int i = waiters - 2; i >= 0; i--)
            begin
                if (waiter_q[i].prio > waiter_q[best].prio)
                    best = i;
            end
            lock_owner = waiter_q[best].id;
            is_waiting[lock_owner] = 1'b0;
            for (int i = best; i < waiters - 1; i++)
                waiter_q[i] = waiter_q[i + 1];
            waiters--;
            ev = EV_HANDED;
        end
        res.event_res    = ev;
        res.owner_id     = lock_taken ? lock_owner : '0;
        res.lock_held    = lock_taken;
        res.waiter_count = PLM_COUNT_W'(waiters);
        return res;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            errs++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        plm_rsp_t want;
        if (!rst_n)
        begin
            lock_taken = 1'b0;
            lock_owner = '0;
            waiters    = 0;
            foreach (is_waiting[i])
                is_waiting[i] = 1'b0;
            lock_results_due.delete();
        end
        else
        begin
            // result first: a beat taken at this edge cannot answer itself
            if (rsp_valid && rsp_ready)
            begin
                checked++;
                if (lock_results_due.size() == 0)
                begin
                    errs++;
                    $error("result beat with nothing expected: event %0d owner %0d",
                           rsp.event_res, rsp.owner_id);
                end
                else
                begin
                    want = lock_results_due.pop_front();
                    check_field("event_res", 8'(want.event_res), 8'(rsp.event_res));
                    check_field("owner_id", 8'(want.owner_id), 8'(rsp.owner_id));
                    check_field("lock_held", 8'(want.lock_held), 8'(rsp.lock_held));
                    check_field("waiter_count", 8'(want.waiter_count),
                                8'(rsp.waiter_count));
                    if (want.event_res == EV_HANDED)
                        handoffs++;
                    if (want.event_res == EV_IGNORED)
                        ignores++;
                end
            end
            if (req_valid && req_ready)
            begin
                lock_results_due.push_back(apply_lock_request(req));
                if (waiters > peak)
                    peak = waiters;
            end
        end
        mismatch_count  <= errs;
        outstanding     <= lock_results_due.size();
        results_checked <= checked;
        handoff_count   <= handoffs;
        ignored_count   <= ignores;
        peak_waiters    <= peak;
    end

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// drives acquire and release beats into the priority lock manager: a short
// directed opening, then random contention bursts, full-queue fills and noise
// under three sender/receiver idling mixes; the checker does the comparing
// ----------------------------------------------------------------------------
module tb import plm_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_BEATS = 2000;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    plm_req_t req       = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    plm_rsp_t rsp;

    // idling odds in percent, changed between phases
    int idle_pct   = 0;
    int stall_pct  = 0;
    int beats_sent = 0;
    int id_pool [PLM_NUM_IDS];

    int mismatch_count;
    int outstanding;
    int results_checked;
    int handoff_count;
    int ignored_count;
    int peak_waiters;

    priority_lock_manager dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    priority_lock_checker lock_watch (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .req             (req),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .rsp             (rsp),
        .mismatch_count  (mismatch_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .handoff_count   (handoff_count),
        .ignored_count   (ignored_count),
        .peak_waiters    (peak_waiters)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // hard stop, several times the slowest honest run
    initial
    begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // one request beat: optional idle cycles, then hold valid until taken
    task automatic send_beat(input logic act, input logic [PLM_ID_W-1:0] id,
                             input logic [PLM_PRIO_W-1:0] prio);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= '{action: act, requester_id: id, priority_req: prio};
        do
            @(posedge clk);
        while (!req_ready);
        beats_sent++;
    endtask

    // narrow priorities make ties common so the newest-wins rule gets exercised
    function automatic logic [PLM_PRIO_W-1:0] pick_prio(bit narrow);
        if (narrow)
            return PLM_PRIO_W'($urandom_range(0, 3));
        return PLM_PRIO_W'($urandom_range(0, 255));
    endfunction

    task automatic shuffle_ids();
        int j;
        int t;
        foreach (id_pool[i])
            id_pool[i] = i;
        for (int i = PLM_NUM_IDS - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = id_pool[i];
            id_pool[i] = id_pool[j];
            id_pool[j] = t;
        end
    endtask

    // a well-formed contention round: someone takes the lock, depth distinct
    // agents queue behind it, then releases drain the queue and free the lock
    task automatic contend(int depth);
        bit narrow;
        narrow = $urandom_range(0, 1);
        shuffle_ids();
        send_beat(ACT_ACQUIRE, PLM_ID_W'($urandom), pick_prio(narrow));
        for (int i = 0; i < depth; i++)
            send_beat(ACT_ACQUIRE, PLM_ID_W'(id_pool[i]), pick_prio(narrow));
        // queue full of every agent: any further acquire is turned away
        if (depth == PLM_NUM_IDS)
            send_beat(ACT_ACQUIRE, PLM_ID_W'($urandom), pick_prio(narrow));
        for (int i = 0; i <= depth; i++)
        begin
            // a late arrival now and then while the hand-offs run
            if ($urandom_range(0, 99) < 15)
                send_beat(ACT_ACQUIRE, PLM_ID_W'($urandom), pick_prio(narrow));
            send_beat(ACT_RELEASE, PLM_ID_W'($urandom), PLM_PRIO_W'($urandom));
        end
        // sometimes one release too many, on a lock that may already be free
        if ($urandom_range(0, 99) < 30)
            send_beat(ACT_RELEASE, PLM_ID_W'($urandom), PLM_PRIO_W'($urandom));
    endtask

    initial
    begin : stimulus
        int pick;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first mix: sender idles a little, receiver stalls a lot
        idle_pct  = 12;
        stall_pct = 46;

        // release of a free lock is ignored
        send_beat(ACT_RELEASE, 6'd63, 8'd255);
        // free lock granted at once, lowest id and priority
        send_beat(ACT_ACQUIRE, 6'd0, 8'd0);
        // owner asks again while holding: queued like anyone else
        send_beat(ACT_ACQUIRE, 6'd0, 8'd255);
        // equal top priority, newer one must win the hand-off
        send_beat(ACT_ACQUIRE, 6'd63, 8'd255);
        // already waiting: duplicate
        send_beat(ACT_ACQUIRE, 6'd63, 8'd7);
        send_beat(ACT_ACQUIRE, 6'd21, 8'd0);
        send_beat(ACT_ACQUIRE, 6'd42, 8'd128);
        // hand-offs: 63, then 0, then 42, then 21, then freed, then ignored
        send_beat(ACT_RELEASE, 6'd0, 8'd0);
        send_beat(ACT_RELEASE, 6'd42, 8'd170);
        send_beat(ACT_RELEASE, 6'd21, 8'd85);
        send_beat(ACT_RELEASE, 6'd63, 8'd255);
        send_beat(ACT_RELEASE, 6'd0, 8'd0);
        send_beat(ACT_RELEASE, 6'd0, 8'd0);
        // alternating bit patterns, tie at the low end
        send_beat(ACT_ACQUIRE, 6'd42, 8'd170);
        send_beat(ACT_ACQUIRE, 6'd21, 8'd85);
        send_beat(ACT_ACQUIRE, 6'd5, 8'd85);
        // a waiter that finished earlier may queue again
        send_beat(ACT_ACQUIRE, 6'd63, 8'd84);
        send_beat(ACT_RELEASE, 6'd21, 8'd85);
        send_beat(ACT_RELEASE, 6'd42, 8'd170);
        send_beat(ACT_RELEASE, 6'd5, 8'd1);
        send_beat(ACT_RELEASE, 6'd0, 8'd254);
        send_beat(ACT_RELEASE, 6'd63, 8'd0);

        // random part, counted in all beats sent so far
        while (beats_sent < TOTAL_BEATS)
        begin
            if (beats_sent < TOTAL_BEATS / 3)
            begin
                idle_pct  = 12;
                stall_pct = 46;
            end
            else if (beats_sent < 2 * TOTAL_BEATS / 3)
            begin
                idle_pct  = 46;
                stall_pct = 12;
            end
            else
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end

            pick = $urandom_range(0, 99);
            if (pick < 2)
                contend(PLM_NUM_IDS);
            else if (pick < 62)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    contend($urandom_range(0, 6));
                else if (pick < 95)
                    contend($urandom_range(7, 20));
                else
                    contend($urandom_range(21, PLM_NUM_IDS - 1));
            end
            else
            begin
                // unstructured noise, acquires and releases at random
                repeat ($urandom_range(1, 8))
                    send_beat(logic'($urandom_range(0, 1)), PLM_ID_W'($urandom),
                              PLM_PRIO_W'($urandom));
            end
        end
        req_valid <= 1'b0;

        // drain, then give the longest hand-off time to show anything stray
        stall_pct = 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);

        $display("%0d request beats sent, %0d results checked, %0d hand-offs, %0d turned away",
                 beats_sent, results_checked, handoff_count, ignored_count);
        $display("deepest waiter queue %0d, idling mixes 12/46, 46/12 and none",
                 peak_waiters);
        if (mismatch_count == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/plm_pkg.sv
rtl/core/plm_queue_ram.sv
rtl/core/priority_lock_manager.sv
test/priority_lock_checker.sv
test/tb.sv
